### src/ecdsader_pkg.sv
// Shared types, constants and lookup functions for the ECDSA signature DER encoder.
package ecdsader_pkg;

  localparam int unsigned SCALAR_BYTES = 32;
  localparam int unsigned SCALAR_W     = 8 * SCALAR_BYTES;
  localparam int unsigned LIMB_W       = 64;
  localparam int unsigned LIMBS        = SCALAR_W / LIMB_W;
  localparam int unsigned LEN_W        = 6;
  localparam int unsigned TOTAL_W      = 7;

  localparam logic [SCALAR_W-1:0] ORDER_N =
    256'hFFFFFFFF00000000_FFFFFFFFFFFFFFFF_BCE6FAADA7179E84_F3B9CAC2FC632551;
  localparam logic [SCALAR_W-1:0] ORDER_HALF = ORDER_N >> 1;

  localparam logic [7:0] TAG_SEQUENCE = 8'h30;
  localparam logic [7:0] TAG_INTEGER  = 8'h02;
  localparam logic [7:0] CAP_RESET    = 8'd72;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_CAP  = 2'd2;

  typedef struct packed {
    logic [63:0] limb_value;
    logic [2:0]  limb_index;
  } sig_in_t;

  typedef struct packed {
    logic [63:0]        out_word;
    logic [3:0]         byte_count;
    logic               last_word;
    logic [TOTAL_W-1:0] total_length;
    logic [1:0]         status;
  } sig_out_t;

  typedef struct packed {
    logic             lt_n;
    logic             gt_half;
    logic             r_nz;
    logic             s_nz;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] s_len;
    logic [LEN_W-1:0] d_len;
    logic             r_top;
    logic             s_top;
    logic             d_top;
  } scan_t;

  typedef struct packed {
    logic       clear;
    logic       push;
    logic       pad;
    logic [7:0] data;
    logic       err;
    logic [1:0] status;
  } pack_ctl_t;

  function automatic logic [7:0] order_byte(input logic [4:0] k);
    return ORDER_N[{k, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] half_byte(input logic [4:0] k);
    return ORDER_HALF[{k, 3'b000} +: 8];
  endfunction

endpackage

### src/ecdsa_signature_der_encoder.sv
// Top level: limb storage, sequencer and byte stream of the ECDSA P-256 DER signature encoder.
// A request with limb_index 0 to 6 stores its limb and busy_o stays low. A request with
// limb_index 7 starts encoding: a byte-serial scan of r, s and n - s, a decision state, an
// align state stripping leading zero bytes, then one signature byte per cycle (at most 72) and
// a flush state of zero fill up to the next 8-byte boundary. Stored limbs survive encoding, so
// a later request may replace single limbs. Results appear on res_o for exactly one cycle with
// res_valid_o; there is no backpressure, so the receiver must take every strobe. An error ends
// encoding in the decision state and gives a single result in the cycle after the decision
// cycle, with busy_o already low. Otherwise busy_o is high from the start of encoding until
// the last result is driven; the capacity register is written through cfg_valid_i/cfg_ready_o
// while busy_o is low.
module ecdsa_signature_der_encoder (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  ecdsader_pkg::sig_in_t  req_i,
  output logic                   busy_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [7:0]             cfg_data_i,
  output logic                   res_valid_o,
  output ecdsader_pkg::sig_out_t res_o
);
  import ecdsader_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SCAN    = 4'd1;
  localparam logic [3:0] ST_DECIDE  = 4'd2;
  localparam logic [3:0] ST_ALIGN   = 4'd3;
  localparam logic [3:0] ST_SEQ_TAG = 4'd4;
  localparam logic [3:0] ST_SEQ_LEN = 4'd5;
  localparam logic [3:0] ST_R_TAG   = 4'd6;
  localparam logic [3:0] ST_R_LEN   = 4'd7;
  localparam logic [3:0] ST_R_PAD   = 4'd8;
  localparam logic [3:0] ST_R_BODY  = 4'd9;
  localparam logic [3:0] ST_S_TAG   = 4'd10;
  localparam logic [3:0] ST_S_LEN   = 4'd11;
  localparam logic [3:0] ST_S_PAD   = 4'd12;
  localparam logic [3:0] ST_S_BODY  = 4'd13;
  localparam logic [3:0] ST_FLUSH   = 4'd14;

  logic [3:0]          state_q, state_d;
  logic [LEN_W-1:0]    cnt_q, cnt_d;
  logic [7:0]          cap_q;
  logic [SCALAR_W-1:0] r_q, s_q, d_q;
  logic [LEN_W-1:0]    rlen_q, slen_q;
  logic                rpad_q, spad_q;
  logic [TOTAL_W-1:0]  total_q;

  logic                accept, enc_start;
  scan_t               scan;
  logic [7:0]          d_byte;
  logic                empty;
  pack_ctl_t           ctl;

  logic                use_d, zero_err, cap_err, r_top_nz, s_top_nz;
  logic [LEN_W-1:0]    s_len_sel;
  logic                s_top_sel;
  logic [TOTAL_W-1:0]  r_enc, s_enc, total_calc;

  assign busy_o      = state_q != ST_IDLE;
  assign cfg_ready_o = !busy_o;
  assign accept      = start_i && !busy_o;
  assign enc_start   = accept && req_i.limb_index == 3'd7;

  assign use_d      = scan.gt_half;
  assign zero_err   = !scan.r_nz || (use_d ? !scan.lt_n : !scan.s_nz);
  assign s_len_sel  = use_d ? scan.d_len : scan.s_len;
  assign s_top_sel  = use_d ? scan.d_top : scan.s_top;
  assign r_enc      = {1'b0, scan.r_len} + {{(TOTAL_W-1){1'b0}}, scan.r_top};
  assign s_enc      = {1'b0, s_len_sel} + {{(TOTAL_W-1){1'b0}}, s_top_sel};
  assign total_calc = TOTAL_W'(6) + r_enc + s_enc;
  assign cap_err    = {1'b0, total_calc} > cap_q;
  assign r_top_nz   = r_q[SCALAR_W-1 -: 8] != 8'd0;
  assign s_top_nz   = d_q[SCALAR_W-1 -: 8] != 8'd0;

  ecdsader_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (enc_start),
    .en_i     (state_q == ST_SCAN),
    .k_i      (cnt_q[4:0]),
    .r_byte_i (r_q[7:0]),
    .s_byte_i (s_q[7:0]),
    .d_byte_o (d_byte),
    .scan_o   (scan)
  );

  ecdsader_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .total_i     (total_q),
    .empty_o     (empty),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ctl        = '0;
    ctl.status = zero_err ? STATUS_ZERO : STATUS_CAP;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (enc_start) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cnt_d = cnt_q + LEN_W'(1);
        if (cnt_q == LEN_W'(SCALAR_BYTES - 1)) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cnt_d     = '0;
        ctl.clear = !(zero_err || cap_err);
        ctl.err   = zero_err || cap_err;
        state_d   = (zero_err || cap_err) ? ST_IDLE : ST_ALIGN;
      end
      ST_ALIGN: begin
        if (r_top_nz && s_top_nz) state_d = ST_SEQ_TAG;
      end
      ST_SEQ_TAG: begin
        ctl.push = 1'b1;
        ctl.data = TAG_SEQUENCE;
        state_d  = ST_SEQ_LEN;
      end
      ST_SEQ_LEN: begin
        ctl.push = 1'b1;
        ctl.data = {1'b0, total_q - TOTAL_W'(2)};
        state_d  = ST_R_TAG;
      end
      ST_R_TAG: begin
        ctl.push = 1'b1;
        ctl.data = TAG_INTEGER;
        state_d  = ST_R_LEN;
      end
      ST_R_LEN: begin
        ctl.push = 1'b1;
        ctl.data = 8'({1'b0, rlen_q} + {{LEN_W{1'b0}}, rpad_q});
        state_d  = rpad_q ? ST_R_PAD : ST_R_BODY;
      end
      ST_R_PAD: begin
        ctl.push = 1'b1;
        ctl.data = 8'd0;
        state_d  = ST_R_BODY;
      end
      ST_R_BODY: begin
        ctl.push = 1'b1;
        ctl.data = r_q[SCALAR_W-1 -: 8];
        cnt_d    = cnt_q + LEN_W'(1);
        if (cnt_q == rlen_q - LEN_W'(1)) begin
          cnt_d   = '0;
          state_d = ST_S_TAG;
        end
      end
      ST_S_TAG: begin
        ctl.push = 1'b1;
        ctl.data = TAG_INTEGER;
        state_d  = ST_S_LEN;
      end
      ST_S_LEN: begin
        ctl.push = 1'b1;
        ctl.data = 8'({1'b0, slen_q} + {{LEN_W{1'b0}}, spad_q});
        state_d  = spad_q ? ST_S_PAD : ST_S_BODY;
      end
      ST_S_PAD: begin
        ctl.push = 1'b1;
        ctl.data = 8'd0;
        state_d  = ST_S_BODY;
      end
      ST_S_BODY: begin
        ctl.push = 1'b1;
        ctl.data = d_q[SCALAR_W-1 -: 8];
        cnt_d    = cnt_q + LEN_W'(1);
        if (cnt_q == slen_q - LEN_W'(1)) begin
          cnt_d   = '0;
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // zero fill until the final word has gone out
        if (empty) begin
          state_d = ST_IDLE;
        end else begin
          ctl.push = 1'b1;
          ctl.pad  = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      cap_q   <= CAP_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) cap_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          for (int j = 0; j < LIMBS; j++) begin
            if (req_i.limb_index[1:0] == 2'(j)) begin
              if (req_i.limb_index[2]) s_q[LIMB_W*(LIMBS-1-j) +: LIMB_W] <= req_i.limb_value;
              else                     r_q[LIMB_W*(LIMBS-1-j) +: LIMB_W] <= req_i.limb_value;
            end
          end
        end
      end
      ST_SCAN: begin
        // rotate r and s by a byte, shift n - s in from the top
        r_q <= {r_q[7:0], r_q[SCALAR_W-1:8]};
        s_q <= {s_q[7:0], s_q[SCALAR_W-1:8]};
        d_q <= {d_byte, d_q[SCALAR_W-1:8]};
      end
      ST_DECIDE: begin
        rlen_q  <= scan.r_len;
        rpad_q  <= scan.r_top;
        slen_q  <= s_len_sel;
        spad_q  <= s_top_sel;
        total_q <= total_calc;
        if (!use_d) d_q <= s_q;
      end
      ST_ALIGN: begin
        // r rotates a full turn over align and body, so the stored limbs stay intact
        if (!r_top_nz) r_q <= {r_q[SCALAR_W-9:0], r_q[SCALAR_W-1 -: 8]};
        if (!s_top_nz) d_q <= {d_q[SCALAR_W-9:0], 8'd0};
      end
      ST_R_BODY: r_q <= {r_q[SCALAR_W-9:0], r_q[SCALAR_W-1 -: 8]};
      ST_S_BODY: d_q <= {d_q[SCALAR_W-9:0], 8'd0};
      default: ;
    endcase
  end

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enc_start |=> state_q == ST_SCAN) else $error("encode not started");
  a_err_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != STATUS_OK |-> state_q == ST_IDLE)
    else $error("error result while running");
  a_last_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_word && res_o.status == STATUS_OK |-> state_q == ST_FLUSH)
    else $error("last word out of place");
  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DECIDE |-> $past(state_q) == ST_SCAN &&
    $past(cnt_q) == LEN_W'(SCALAR_BYTES - 1)) else $error("short scan");

endmodule

### src/ecdsader_scan.sv
// Byte-serial scan of r and s: low-S compares, n - s borrow chain, lengths and zero flags.
module ecdsader_scan (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clear_i,
  input  logic                  en_i,
  input  logic [4:0]            k_i,
  input  logic [7:0]            r_byte_i,
  input  logic [7:0]            s_byte_i,
  output logic [7:0]            d_byte_o,
  output ecdsader_pkg::scan_t   scan_o
);
  import ecdsader_pkg::*;

  scan_t            scan_q, scan_d;
  logic             borrow_q, borrow_d;
  logic [7:0]       nb, hb;
  logic [8:0]       diff;
  logic [LEN_W-1:0] len_here;

  assign nb       = order_byte(k_i);
  assign hb       = half_byte(k_i);
  assign diff     = {1'b0, nb} - {1'b0, s_byte_i} - {8'd0, borrow_q};
  assign d_byte_o = diff[7:0];
  assign len_here = {1'b0, k_i} + LEN_W'(1);
  assign scan_o   = scan_q;

  always_comb begin
    scan_d   = scan_q;
    borrow_d = borrow_q;
    if (clear_i) begin
      scan_d   = '0;
      borrow_d = 1'b0;
    end else if (en_i) begin
      borrow_d = diff[8];
      if (s_byte_i != hb) scan_d.gt_half = s_byte_i > hb;
      if (s_byte_i != nb) scan_d.lt_n = s_byte_i < nb;
      if (r_byte_i != 8'd0) begin
        scan_d.r_nz  = 1'b1;
        scan_d.r_len = len_here;
        scan_d.r_top = r_byte_i[7];
      end
      if (s_byte_i != 8'd0) begin
        scan_d.s_nz  = 1'b1;
        scan_d.s_len = len_here;
        scan_d.s_top = s_byte_i[7];
      end
      if (diff[7:0] != 8'd0) begin
        scan_d.d_len = len_here;
        scan_d.d_top = diff[7];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q   <= '0;
      borrow_q <= 1'b0;
    end else begin
      scan_q   <= scan_d;
      borrow_q <= borrow_d;
    end
  end

  // a nonzero s byte always sets its length to a nonzero value
  a_len_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q.s_nz |-> scan_q.s_len != '0) else $error("s length lost");
  a_r_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q.r_nz |-> scan_q.r_len != '0) else $error("r length lost");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_i |=> !scan_q.r_nz && !scan_q.s_nz && !borrow_q) else $error("scan not cleared");

endmodule

### src/ecdsader_pack.sv
// Packs the byte stream into left-aligned 64-bit result words and drives the result register.
module ecdsader_pack (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ecdsader_pkg::pack_ctl_t            ctl_i,
  input  logic [ecdsader_pkg::TOTAL_W-1:0]   total_i,
  output logic                               empty_o,
  output logic                               res_valid_o,
  output ecdsader_pkg::sig_out_t             res_o
);
  import ecdsader_pkg::*;

  logic [63:0]        word_q, word_n;
  logic [2:0]         pos_q;
  logic [3:0]         vcnt_q, vcnt_n;
  logic [TOTAL_W-1:0] bcnt_q, bcnt_n;
  logic               valid_q;
  sig_out_t           res_q;

  assign word_n  = {word_q[55:0], ctl_i.pad ? 8'd0 : ctl_i.data};
  assign vcnt_n  = vcnt_q + {3'd0, !ctl_i.pad};
  assign bcnt_n  = bcnt_q + {{(TOTAL_W-1){1'b0}}, !ctl_i.pad};
  assign empty_o = pos_q == 3'd0;
  assign res_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      vcnt_q  <= '0;
      bcnt_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      if (ctl_i.clear) begin
        pos_q  <= '0;
        vcnt_q <= '0;
        bcnt_q <= '0;
      end else if (ctl_i.err) begin
        valid_q <= 1'b1;
      end else if (ctl_i.push) begin
        pos_q  <= pos_q + 3'd1;
        bcnt_q <= bcnt_n;
        if (pos_q == 3'd7) begin
          vcnt_q  <= '0;
          valid_q <= 1'b1;
        end else begin
          vcnt_q <= vcnt_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= ctl_i.push ? word_n : word_q;
    if (ctl_i.err) begin
      res_q.out_word     <= '0;
      res_q.byte_count   <= '0;
      res_q.last_word    <= 1'b1;
      res_q.total_length <= '0;
      res_q.status       <= ctl_i.status;
    end else if (ctl_i.push && pos_q == 3'd7) begin
      res_q.out_word     <= word_n;
      res_q.byte_count   <= vcnt_n;
      res_q.last_word    <= bcnt_n == total_i;
      res_q.total_length <= total_i;
      res_q.status       <= STATUS_OK;
    end
  end

  a_ok_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == STATUS_OK |-> res_o.byte_count != 4'd0 &&
    res_o.byte_count <= 4'd8) else $error("bad byte count");
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != STATUS_OK |-> res_o.byte_count == 4'd0 &&
    res_o.last_word && res_o.out_word == 64'd0) else $error("bad error result");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push |-> !ctl_i.err && !ctl_i.clear) else $error("push collides");

endmodule

### tb/ecdsa_signature_der_encoder_checker.sv
// Checker for the ECDSA DER signature encoder: tracks requests, predicts result words, compares.
module ecdsa_signature_der_encoder_checker
  import ecdsader_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  sig_in_t     req_i,
  input  logic        busy_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        res_valid_i,
  input  sig_out_t    res_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] LAST_LIMB = 3'd7;
  localparam int unsigned SIG_BYTES_MAX = 2 + 2 * (3 + SCALAR_BYTES);

  logic [LIMB_W-1:0] r_store [LIMBS];
  logic [LIMB_W-1:0] s_store [LIMBS];
  logic [7:0]        capacity;
  logic [7:0]        der_bytes [SIG_BYTES_MAX];
  int unsigned       der_len;
  sig_out_t          expected_words [$];

  task automatic append_integer(input logic [SCALAR_W-1:0] v);
    int unsigned first;
    int unsigned i;
    logic [7:0]  lead;
    first = 0;
    while (first < SCALAR_BYTES - 1 && v[SCALAR_W-1-8*first -: 8] == 8'h00) first++;
    lead = v[SCALAR_W-1-8*first -: 8];
    der_bytes[der_len]     = TAG_INTEGER;
    der_bytes[der_len + 1] = 8'(SCALAR_BYTES - first + lead[7]);
    der_len += 2;
    if (lead[7]) begin
      der_bytes[der_len] = 8'h00;
      der_len++;
    end
    for (i = first; i < SCALAR_BYTES; i++) begin
      der_bytes[der_len] = v[SCALAR_W-1-8*i -: 8];
      der_len++;
    end
  endtask

  task automatic encode_signature(input logic [SCALAR_W-1:0] r, input logic [SCALAR_W-1:0] s);
    logic [SCALAR_W-1:0] s_low;
    logic [1:0]          status;
    sig_out_t            word;
    int unsigned         nwords;
    int unsigned         cnt;
    int unsigned         w;
    int unsigned         b;
    s_low  = s;
    status = STATUS_OK;
    // low-S form; wraps when s > n, which is flagged below
    if (s > ORDER_HALF) s_low = ORDER_N - s;
    if (r == '0 || s >= ORDER_N || s_low == '0) begin
      status = STATUS_ZERO;
    end else begin
      der_len = 2;
      append_integer(r);
      append_integer(s_low);
      if (der_len - 2 > 127 || der_len > capacity) status = STATUS_CAP;
    end
    if (status != STATUS_OK) begin
      word           = '0;
      word.last_word = 1'b1;
      word.status    = status;
      expected_words.push_back(word);
    end else begin
      der_bytes[0] = TAG_SEQUENCE;
      der_bytes[1] = 8'(der_len - 2);
      nwords = (der_len + 7) / 8;
      for (w = 0; w < nwords; w++) begin
        cnt = der_len - 8 * w;
        if (cnt > 8) cnt = 8;
        word = '0;
        for (b = 0; b < cnt; b++) word.out_word[63-8*b -: 8] = der_bytes[8*w + b];
        word.byte_count   = 4'(cnt);
        word.last_word    = (w + 1 == nwords);
        word.total_length = 7'(der_len);
        word.status       = STATUS_OK;
        expected_words.push_back(word);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sig_out_t want;
    if (!rst_ni) begin
      foreach (r_store[i]) begin
        r_store[i] = '0;
        s_store[i] = '0;
      end
      capacity = CAP_RESET;
      expected_words.delete();
      mismatch_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) capacity = cfg_data_i;
      if (res_valid_i) begin
        if (expected_words.size() == 0) begin
          $error("result word %h with nothing expected", res_i.out_word);
          mismatch_count_o++;
        end else begin
          want = expected_words.pop_front();
          if (res_i.out_word !== want.out_word) begin
            $error("out_word: expected %h, got %h", want.out_word, res_i.out_word);
            mismatch_count_o++;
          end
          if (res_i.byte_count !== want.byte_count) begin
            $error("byte_count: expected %0d, got %0d", want.byte_count, res_i.byte_count);
            mismatch_count_o++;
          end
          if (res_i.last_word !== want.last_word) begin
            $error("last_word: expected %0d, got %0d", want.last_word, res_i.last_word);
            mismatch_count_o++;
          end
          if (res_i.total_length !== want.total_length) begin
            $error("total_length: expected %0d, got %0d", want.total_length,
                   res_i.total_length);
            mismatch_count_o++;
          end
          if (res_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_i.status);
            mismatch_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        if (req_i.limb_index[2]) s_store[req_i.limb_index[1:0]] = req_i.limb_value;
        else                     r_store[req_i.limb_index[1:0]] = req_i.limb_value;
        if (req_i.limb_index == LAST_LIMB)
          encode_signature({r_store[0], r_store[1], r_store[2], r_store[3]},
                           {s_store[0], s_store[1], s_store[2], s_store[3]});
      end
    end
    pending_o = expected_words.size();
  end

endmodule

### tb/ecdsa_signature_der_encoder_test.sv
// Testbench top for the ECDSA DER signature encoder: clock, reset, request and capacity stimulus.
module ecdsa_signature_der_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ecdsader_pkg::*;

  localparam logic [2:0]  LAST_LIMB   = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 50;

  logic        clk;
  logic        rst_n;
  logic        start;
  sig_in_t     req;
  logic        busy;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        res_valid;
  sig_out_t    res;
  logic        req_taken;
  logic        cfg_taken;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned cycles;

  ecdsa_signature_der_encoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .req_i       (req),
    .busy_o      (busy),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ecdsa_signature_der_encoder_checker der_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .req_i            (req),
    .busy_i           (busy),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .res_valid_i      (res_valid),
    .res_i            (res),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_taken <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      req_taken <= start && !busy;
      cfg_taken <= cfg_valid && cfg_ready;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken,
  // plus a gap when a burst ends.
  task automatic issue_limb(input logic [2:0] index, input logic [63:0] value);
    int unsigned gap;
    start <= 1'b1;
    req   <= {value, index};
    do @(negedge clk); while (!req_taken);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(1, 8);
    end else begin
      burst_left--;
      gap = 0;
    end
    if (gap != 0) begin
      start <= 1'b0;
      req   <= {$urandom, $urandom, 3'($urandom)};
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_scalars(input logic [SCALAR_W-1:0] r, input logic [SCALAR_W-1:0] s);
    int unsigned i;
    for (i = 0; i < LIMBS; i++) issue_limb(3'(i), r[SCALAR_W-1-LIMB_W*i -: LIMB_W]);
    for (i = 0; i < LIMBS; i++) issue_limb(3'(LIMBS + i), s[SCALAR_W-1-LIMB_W*i -: LIMB_W]);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [7:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
    cfg_data  <= 8'($urandom);
  endtask

  function automatic logic [SCALAR_W-1:0] pick_scalar();
    logic [SCALAR_W-1:0] v;
    int unsigned         pick;
    int unsigned         k;
    v    = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick >= 35 && pick < 70) begin
      // short magnitude, top bit of the leading byte forced either way
      k = $urandom_range(0, SCALAR_BYTES - 1);
      v = v >> (8 * k);
      v[SCALAR_W-1-8*k] = 1'($urandom_range(0, 1));
    end else if (pick >= 70 && pick < 75) begin
      v = '0;
    end else if (pick >= 75 && pick < 80) begin
      v = 256'd1;
    end else if (pick >= 80) begin
      case ($urandom_range(0, 7))
        0:       v = ORDER_N - 256'd1;
        1:       v = ORDER_N;
        2:       v = ORDER_N + 256'd1;
        3:       v = ORDER_HALF;
        4:       v = ORDER_HALF + 256'd1;
        5:       v = ORDER_HALF - 256'd1;
        6:       v = '1;
        default: v = ORDER_N - 256'($urandom_range(1, 65535));
      endcase
    end
    return v;
  endfunction

  initial begin
    logic [SCALAR_W-1:0] s_val;
    logic [7:0]          caps [6];
    int unsigned         pick;
    int unsigned         phase_end;
    int unsigned         phase;
    int unsigned         i;
    caps       = '{8'd255, 8'd0, 8'd71, 8'd70, 8'd72, 8'd8};
    cycles     = 0;
    items_sent = 0;
    burst_left = 0;
    rst_n      = 1'b0;
    start      = 1'b0;
    req        = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: s equal to n, s above n, r not below n, zero s, one-byte r with pad,
    // zero r, s just above half
    send_scalars('1, ORDER_N);
    issue_limb(LAST_LIMB, ORDER_N[63:0] + 64'd1);
    issue_limb(3'd4, 64'd0);
    issue_limb(3'd5, 64'd0);
    issue_limb(3'd6, 64'd0);
    issue_limb(LAST_LIMB, 64'd1);
    issue_limb(LAST_LIMB, 64'd0);
    issue_limb(3'd0, 64'd0);
    issue_limb(3'd1, 64'd0);
    issue_limb(3'd2, 64'd0);
    issue_limb(3'd3, 64'h80);
    issue_limb(LAST_LIMB, 64'h7f);
    issue_limb(3'd3, 64'd0);
    issue_limb(LAST_LIMB, 64'd1);
    issue_limb(3'd3, 64'd1);
    s_val = ORDER_HALF + 256'd1;
    for (i = 0; i < LIMBS; i++) issue_limb(3'(LIMBS + i), s_val[SCALAR_W-1-LIMB_W*i -: LIMB_W]);

    for (phase = 0; phase < 7; phase++) begin
      write_capacity(phase < 6 ? caps[phase] : 8'($urandom_range(40, 75)));
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          send_scalars(pick_scalar(), pick_scalar());
        end else if (pick < 90) begin
          s_val = pick_scalar();
          for (i = 0; i < LIMBS; i++)
            issue_limb(3'(LIMBS + i), s_val[SCALAR_W-1-LIMB_W*i -: LIMB_W]);
        end else begin
          repeat ($urandom_range(1, 4))
            issue_limb(3'($urandom_range(0, 7)), {$urandom, $urandom});
        end
      end
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
src/ecdsader_pkg.sv
src/ecdsader_scan.sv
src/ecdsader_pack.sv
src/ecdsa_signature_der_encoder.sv
tb/ecdsa_signature_der_encoder_checker.sv
tb/ecdsa_signature_der_encoder_test.sv
